// ----- rtl/core/passive_cell_balance_controller_defines.svh -----
// Assertion helpers used by the balancer RTL.
`ifndef PASSIVE_CELL_BALANCE_CONTROLLER_DEFINES_SVH
`define PASSIVE_CELL_BALANCE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PCB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcb check failed");

// Next-cycle implication, disabled while in reset.
`define PCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcb check failed");

`endif

// ----- rtl/core/pcb_pkg.sv -----
package pcb_pkg;

  localparam int CELL_W    = 13;
  localparam int CUR_W     = 16;
  localparam int TIME_W    = 32;
  localparam int SEL_W     = 3;
  localparam int DRIVE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  // Operation codes carried in tuser
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_STOP   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_CURRENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_STOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME     = 3'd5;

  // Cell numbers
  localparam logic [SEL_W-1:0] CELL_NONE  = 3'd0;
  localparam logic [SEL_W-1:0] CELL_ONE   = 3'd1;
  localparam logic [SEL_W-1:0] CELL_TWO   = 3'd2;
  localparam logic [SEL_W-1:0] CELL_THREE = 3'd3;
  localparam logic [SEL_W-1:0] CELL_FOUR  = 3'd4;

  typedef struct packed {
    logic [CUR_W-1:0]  idle_current_ma;
    logic [CELL_W-1:0] min_cell_mv;
    logic [CELL_W-1:0] delta_start_mv;
    logic [CELL_W-1:0] delta_stop_mv;
    logic [TIME_W-1:0] on_time_ms;
    logic [TIME_W-1:0] off_time_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    idle_current_ma: 16'd200,
    min_cell_mv:     13'd3400,
    delta_start_mv:  13'd30,
    delta_stop_mv:   13'd10,
    on_time_ms:      32'd30000,
    off_time_ms:     32'd5000
  };

  typedef struct packed {
    logic             may_start;
    logic             must_stop;
    logic [SEL_W-1:0] max_idx;
  } eval_t;

  typedef struct packed {
    logic               active;
    logic               on_phase;
    logic [SEL_W-1:0]   selected_cell;
    logic [DRIVE_W-1:0] bleed_drive;
  } result_t;

  typedef struct packed {
    logic             session_active;
    logic             bleeding_now;
    logic [SEL_W-1:0] chosen_cell;
  } status_t;

endpackage

// ----- rtl/core/pcb_eval.sv -----
module pcb_eval (
  input  logic [pcb_pkg::CELL_W-1:0] cell_one_mv,
  input  logic [pcb_pkg::CELL_W-1:0] cell_two_mv,
  input  logic [pcb_pkg::CELL_W-1:0] cell_three_mv,
  input  logic [pcb_pkg::CELL_W-1:0] cell_four_mv,
  input  logic [pcb_pkg::CUR_W-1:0]  pack_current_ma,
  input  pcb_pkg::cfg_t              cfg,
  output pcb_pkg::eval_t             eval
);
  import pcb_pkg::*;

  logic [CELL_W-1:0] vmax;
  logic [CELL_W-1:0] vmin;
  logic [SEL_W-1:0]  max_idx;
  logic [CELL_W-1:0] delta;
  logic [CUR_W:0]    mag;
  logic              idle;

  // Highest cell keeps the lowest number on a tie: update on strictly greater only.
  always_comb begin
    vmax    = cell_one_mv;
    vmin    = cell_one_mv;
    max_idx = CELL_ONE;
    if (cell_two_mv > vmax) begin
      vmax    = cell_two_mv;
      max_idx = CELL_TWO;
    end
    if (cell_two_mv < vmin) vmin = cell_two_mv;
    if (cell_three_mv > vmax) begin
      vmax    = cell_three_mv;
      max_idx = CELL_THREE;
    end
    if (cell_three_mv < vmin) vmin = cell_three_mv;
    if (cell_four_mv > vmax) begin
      vmax    = cell_four_mv;
      max_idx = CELL_FOUR;
    end
    if (cell_four_mv < vmin) vmin = cell_four_mv;
  end

  assign delta = vmax - vmin;

  // 17-bit magnitude so the most negative current reads as 32768.
  assign mag  = pack_current_ma[CUR_W-1] ? ({1'b0, ~pack_current_ma} + 17'd1)
                                         : {1'b0, pack_current_ma};
  assign idle = mag < {1'b0, cfg.idle_current_ma};

  assign eval.may_start = idle && (vmax >= cfg.min_cell_mv) && (delta >= cfg.delta_start_mv);
  assign eval.must_stop = !idle || (delta <= cfg.delta_stop_mv);
  assign eval.max_idx   = max_idx;

endmodule

// ----- rtl/core/pcb_session.sv -----
module pcb_session (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       operation,
  input  logic [pcb_pkg::TIME_W-1:0] now_ms,
  input  pcb_pkg::eval_t             eval,
  input  pcb_pkg::cfg_t              cfg,
  output pcb_pkg::result_t           result_next,
  output pcb_pkg::status_t           status
);
  import pcb_pkg::*;

  logic              session_active, session_active_next;
  logic              bleeding_now, bleeding_now_next;
  logic [SEL_W-1:0]  chosen_cell, chosen_cell_next;
  logic [TIME_W-1:0] phase_start_ms, phase_start_ms_next;
  logic [TIME_W-1:0] elapsed;
  logic [SEL_W-1:0]  sel;

  assign elapsed = now_ms - phase_start_ms;

  always_comb begin
    session_active_next = session_active;
    bleeding_now_next   = bleeding_now;
    chosen_cell_next    = chosen_cell;
    phase_start_ms_next = phase_start_ms;
    if (operation == OP_STOP) begin
      session_active_next = 1'b0;
      bleeding_now_next   = 1'b0;
      phase_start_ms_next = '0;
    end else if (!session_active) begin
      if (eval.may_start) begin
        session_active_next = 1'b1;
        bleeding_now_next   = 1'b1;
        chosen_cell_next    = eval.max_idx;
        phase_start_ms_next = now_ms;
      end
    end else if (eval.must_stop) begin
      session_active_next = 1'b0;
      bleeding_now_next   = 1'b0;
      phase_start_ms_next = '0;
    end else if (bleeding_now) begin
      if (elapsed >= cfg.on_time_ms) begin
        bleeding_now_next   = 1'b0;
        phase_start_ms_next = now_ms;
      end
    end else if (elapsed >= cfg.off_time_ms) begin
      bleeding_now_next   = 1'b1;
      phase_start_ms_next = now_ms;
      chosen_cell_next    = eval.max_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      bleeding_now   <= 1'b0;
      chosen_cell    <= CELL_NONE;
      phase_start_ms <= '0;
    end else if (advance) begin
      session_active <= session_active_next;
      bleeding_now   <= bleeding_now_next;
      chosen_cell    <= chosen_cell_next;
      phase_start_ms <= phase_start_ms_next;
    end
  end

  assign sel = session_active_next ? chosen_cell_next : CELL_NONE;

  always_comb begin
    result_next.active        = session_active_next;
    result_next.on_phase      = session_active_next && bleeding_now_next;
    result_next.selected_cell = sel;
    result_next.bleed_drive   = '0;
    if (session_active_next && bleeding_now_next) begin
      case (sel)
        CELL_ONE:   result_next.bleed_drive = 4'b0001;
        CELL_TWO:   result_next.bleed_drive = 4'b0010;
        CELL_THREE: result_next.bleed_drive = 4'b0100;
        CELL_FOUR:  result_next.bleed_drive = 4'b1000;
        default:    result_next.bleed_drive = '0;
      endcase
    end
  end

  assign status.session_active = session_active;
  assign status.bleeding_now   = bleeding_now;
  assign status.chosen_cell    = chosen_cell;

endmodule

// ----- rtl/core/passive_cell_balance_controller.sv -----
// Pipeline: an accepted word waits in the input register, then loads the result register,
//   where its result word becomes valid; a stalling sink holds it back in the input register.
// Throughput: one word per cycle while the sink does not stall; the session state updates
//   in the same cycle the result register loads, so back-to-back words see each other's state.
// Reset: rst is synchronous, active high; clears both pipeline valids, the session
//   state and restores every configuration register to its default.
`include "passive_cell_balance_controller_defines.svh"

module passive_cell_balance_controller (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcb_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata, low bit up: cell_one_mv[12:0], cell_two_mv[25:13], cell_three_mv[38:26],
  //   cell_four_mv[51:39], pack_current_ma[67:52], now_ms[99:68], zero pad[103:100]
  input  logic [pcb_pkg::IN_DATA_W-1:0] s_tdata,
  // tuser: operation[0]
  input  logic                          s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata, low bit up: active[0], on_phase[1], selected_cell[4:2], bleed_drive[8:5],
  //   zero pad[15:9]
  output logic [pcb_pkg::OUT_DATA_W-1:0] m_tdata
);
  import pcb_pkg::*;

  cfg_t    cfg;
  eval_t   eval;
  result_t result_next;
  result_t result_q;
  status_t status;

  logic                  in_valid;
  logic                  in_op;
  logic [IN_DATA_W-1:0]  in_data;
  logic                  out_valid;
  logic                  advance;

  // Configuration registers; write them only while no word is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IDLE_CURRENT: cfg.idle_current_ma <= cfg_wdata[CUR_W-1:0];
        REG_MIN_CELL:     cfg.min_cell_mv     <= cfg_wdata[CELL_W-1:0];
        REG_DELTA_START:  cfg.delta_start_mv  <= cfg_wdata[CELL_W-1:0];
        REG_DELTA_STOP:   cfg.delta_stop_mv   <= cfg_wdata[CELL_W-1:0];
        REG_ON_TIME:      cfg.on_time_ms      <= cfg_wdata[TIME_W-1:0];
        REG_OFF_TIME:     cfg.off_time_ms     <= cfg_wdata[TIME_W-1:0];
        default:          ;
      endcase
    end
  end

  // Advance the held word into the result register whenever that register is free
  // or draining this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register: control valid resets, payload just loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_data <= s_tdata;
    end
  end

  pcb_eval u_eval (
    .cell_one_mv     (in_data[12:0]),
    .cell_two_mv     (in_data[25:13]),
    .cell_three_mv   (in_data[38:26]),
    .cell_four_mv    (in_data[51:39]),
    .pack_current_ma (in_data[67:52]),
    .cfg             (cfg),
    .eval            (eval)
  );

  pcb_session u_session (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .operation   (in_op),
    .now_ms      (in_data[99:68]),
    .eval        (eval),
    .cfg         (cfg),
    .result_next (result_next),
    .status      (status)
  );

  // Result register: hold while the sink stalls, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-9){1'b0}}, result_q.bleed_drive, result_q.selected_cell,
                     result_q.on_phase, result_q.active};

  // Bleeding only happens inside a session.
  `PCB_ASSERT_SAME(a_bleed_in_session, clk, rst, status.bleeding_now, status.session_active)
  // A running session always has a real cell chosen.
  `PCB_ASSERT_SAME(a_cell_valid, clk, rst, status.session_active,
                   (status.chosen_cell == CELL_ONE) || (status.chosen_cell == CELL_TWO) ||
                   (status.chosen_cell == CELL_THREE) || (status.chosen_cell == CELL_FOUR))
  // A manual stop leaves the session closed.
  `PCB_ASSERT_NEXT(a_stop_ends, clk, rst, advance && (in_op == OP_STOP),
                   !status.session_active && !status.bleeding_now)
  // Every advanced word shows up in the result register.
  `PCB_ASSERT_NEXT(a_advance_loads, clk, rst, advance, out_valid)

endmodule
